// ----- rtl/spq_pkg.sv -----
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and codes for the stable priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int DATA_W = 32;
    localparam int PRIO_W = 8;
    localparam int OCC_W  = 5;

    typedef enum logic {
        KIND_ENQ = 1'b0,
        KIND_DEQ = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_SHIFT
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        logic     occupied;
    } t_cell_ctrl;

endpackage

// ----- rtl/spq_if.sv -----
// ----------------------------------------------------------------------------
// spq_if
// Request and response channels of the stable priority queue.
// ----------------------------------------------------------------------------
interface spq_req_if;
    logic               valid;
    logic               ready;
    logic               kind;
    logic signed [31:0] in_data;
    logic        [7:0]  in_priority;

    modport source (output valid, output kind, output in_data, output in_priority,
                    input ready);
    modport sink   (input valid, input kind, input in_data, input in_priority,
                    output ready);
endinterface

interface spq_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] out_data;
    logic        [1:0]  status;
    logic        [4:0]  occupancy;

    modport source (output valid, output out_data, output status, output occupancy,
                    input ready);
    modport sink   (input valid, input out_data, input status, input occupancy,
                    output ready);
endinterface

// ----- rtl/spq_cell.sv -----
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted row: holds an entry and moves it to or from a neighbor.
// ----------------------------------------------------------------------------
module spq_cell
    import spq_pkg::*;
(
    input  logic                     i_clk,
    input  t_cell_ctrl               i_ctrl,
    input  logic signed [DATA_W-1:0] i_new_data,
    input  logic        [PRIO_W-1:0] i_new_prio,
    input  logic signed [DATA_W-1:0] i_prev_data,
    input  logic        [PRIO_W-1:0] i_prev_prio,
    input  logic                     i_prev_behind,
    input  logic signed [DATA_W-1:0] i_next_data,
    input  logic        [PRIO_W-1:0] i_next_prio,
    output logic signed [DATA_W-1:0] o_data,
    output logic        [PRIO_W-1:0] o_prio,
    output logic                     o_behind
);

    logic signed [DATA_W-1:0] r_data, n_data;
    logic        [PRIO_W-1:0] r_prio, n_prio;

    // The new entry goes behind this one when it is stored and not of higher priority.
    assign o_behind = i_ctrl.occupied && (r_prio <= i_new_prio);

    always_comb begin
        n_data = r_data;
        n_prio = r_prio;
        case (i_ctrl.op)
            OP_INSERT: begin
                if (o_behind) begin
                    n_data = r_data;
                    n_prio = r_prio;
                end else if (i_prev_behind) begin
                    n_data = i_new_data;
                    n_prio = i_new_prio;
                end else begin
                    n_data = i_prev_data;
                    n_prio = i_prev_prio;
                end
            end
            OP_SHIFT: begin
                n_data = i_next_data;
                n_prio = i_next_prio;
            end
            default: begin
                n_data = r_data;
                n_prio = r_prio;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        r_prio <= n_prio;
    end

    assign o_data = r_data;
    assign o_prio = r_prio;

endmodule

// ----- rtl/stable_priority_queue.sv -----
// ----------------------------------------------------------------------------
// stable_priority_queue
// Bounded priority queue kept as a sorted row of cells, front at cell 0.
// ----------------------------------------------------------------------------
//  Channel  Dir  Payload                            Moves
//  i_req    in   kind, in_data, in_priority         one operation
//  o_rsp    out  out_data, status, occupancy        one result per operation
//
//  One transaction per cycle while the result register is empty or draining:
//  every cell compares its priority with the incoming one and shifts in the
//  same cycle. The registered result appears in the cycle after acceptance.
//  A request is taken whenever the result register is empty or being drained.
//  Reset empties the queue; the cell contents are not cleared.
// ----------------------------------------------------------------------------
module stable_priority_queue
    import spq_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    spq_req_if.sink   i_req,
    spq_rsp_if.source o_rsp
);

    localparam int CW = $clog2(CAPACITY + 1);

    logic signed [DATA_W-1:0] cell_data  [CAPACITY];
    logic        [PRIO_W-1:0] cell_prio  [CAPACITY];
    logic                     cell_behind[CAPACITY];

    logic [CW-1:0]            r_count, n_count;
    logic                     r_out_valid;
    logic signed [DATA_W-1:0] r_out_data, n_out_data;
    t_status                  r_status, n_status;
    logic [OCC_W-1:0]         r_occ;
    t_cell_op                 cell_op;
    logic                     accept;

    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign accept      = i_req.valid && i_req.ready;

    always_comb begin
        cell_op    = OP_HOLD;
        n_count    = r_count;
        n_out_data = '0;
        n_status   = ST_OK;
        if (i_req.kind == KIND_ENQ) begin
            if (r_count >= CW'(CAPACITY)) begin
                n_status = ST_FULL;
            end else begin
                cell_op = OP_INSERT;
                n_count = r_count + 1'b1;
            end
        end else begin
            if (r_count == '0) begin
                n_status = ST_EMPTY;
            end else begin
                cell_op    = OP_SHIFT;
                n_count    = r_count - 1'b1;
                n_out_data = cell_data[0];
            end
        end
        if (!accept) begin
            cell_op = OP_HOLD;
            n_count = r_count;
        end
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_cell_ctrl               ctrl;
        logic signed [DATA_W-1:0] prev_data, next_data;
        logic        [PRIO_W-1:0] prev_prio, next_prio;
        logic                     prev_behind;

        assign ctrl.op       = cell_op;
        assign ctrl.occupied = CW'(g) < r_count;

        if (g == 0) begin : g_first
            assign prev_data   = i_req.in_data;
            assign prev_prio   = i_req.in_priority;
            assign prev_behind = 1'b1;
        end else begin : g_mid
            assign prev_data   = cell_data[g-1];
            assign prev_prio   = cell_prio[g-1];
            assign prev_behind = cell_behind[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign next_data = cell_data[g];
            assign next_prio = cell_prio[g];
        end else begin : g_inner
            assign next_data = cell_data[g+1];
            assign next_prio = cell_prio[g+1];
        end

        spq_cell u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (ctrl),
            .i_new_data   (i_req.in_data),
            .i_new_prio   (i_req.in_priority),
            .i_prev_data  (prev_data),
            .i_prev_prio  (prev_prio),
            .i_prev_behind(prev_behind),
            .i_next_data  (next_data),
            .i_next_prio  (next_prio),
            .o_data       (cell_data[g]),
            .o_prio       (cell_prio[g]),
            .o_behind     (cell_behind[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_data <= n_out_data;
            r_status   <= n_status;
            r_occ      <= OCC_W'(n_count);
        end
    end

    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.out_data  = r_out_data;
    assign o_rsp.status    = r_status;
    assign o_rsp.occupancy = r_occ;

endmodule

// ----- rtl/spq_checker.sv -----
// ----------------------------------------------------------------------------
// spq_checker
// Port-level checks on the stable priority queue.
// ----------------------------------------------------------------------------
module spq_checker
    import spq_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_in_valid,
    input logic                     i_in_ready,
    input logic                     i_out_valid,
    input logic                     i_out_ready,
    input logic signed [DATA_W-1:0] i_out_data,
    input logic        [1:0]        i_status,
    input logic        [OCC_W-1:0]  i_occupancy
);

    // A held result keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data)
            && $stable(i_status) && $stable(i_occupancy))
        else $error("result changed while stalled");

    // Each accepted transaction yields a result in the next cycle.
    a_resp_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> i_out_valid)
        else $error("no result after accepted transaction");

    // With no result pending the queue must accept.
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("request stalled with empty result register");

    // An empty dequeue reports no data and an empty queue.
    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status == ST_EMPTY |-> i_out_data == '0 && i_occupancy == '0)
        else $error("empty dequeue with data or occupancy");

    // Occupancy never exceeds the capacity.
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (CAPACITY > 31) || (int'(i_occupancy) <= CAPACITY))
        else $error("occupancy beyond capacity");

endmodule

bind stable_priority_queue spq_checker #(.CAPACITY(CAPACITY)) u_spq_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_req.valid),
    .i_in_ready (i_req.ready),
    .i_out_valid(o_rsp.valid),
    .i_out_ready(o_rsp.ready),
    .i_out_data (o_rsp.out_data),
    .i_status   (o_rsp.status),
    .i_occupancy(o_rsp.occupancy)
);
